// ===== hw/rtl/visible_byte_escaper_top_assert.svh =====
// assertion macros for the visible byte escaper top level
`ifndef VISIBLE_BYTE_ESCAPER_TOP_ASSERT_SVH
`define VISIBLE_BYTE_ESCAPER_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define VBE_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("visible_byte_escaper: same-cycle check failed");

// next-cycle implication, quiet while reset is high
`define VBE_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("visible_byte_escaper: next-cycle check failed");

// next-cycle implication that also holds across reset
`define VBE_ASSERT_RESET_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) (cond) |=> (prop)) \
      else $error("visible_byte_escaper: reset check failed");

`endif

// ===== hw/rtl/vbe_pkg.sv =====
// shared types and constants of the visible byte escaper
`timescale 1ns / 1ps

package vbe_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;

   localparam logic [7:0] FOLD_RESET     = 8'd66;
   localparam logic [7:0] FOLD_INDENT    = 8'd8;
   localparam logic [7:0] TAB_MASK       = 8'd7;

   typedef enum logic [1:0] {
      CSR_STRIP_MODE  = 2'd0,
      CSR_RAW_TABS    = 2'd1,
      CSR_FOLD_COLUMN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PLAIN   = 2'd0,
      KIND_NL_MARK = 2'd1,
      KIND_PAIR    = 2'd2,
      KIND_OCTAL   = 2'd3
   } kind_type;

   // one queued rendering job
   typedef struct packed {
      logic       fold;
      kind_type   kind;
      logic [7:0] data;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/vbe_front.sv =====
// front end: accepts bytes, tracks column state and classifies each byte into a job
`timescale 1ns / 1ps

module vbe_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] in_byte
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [7:0]                 csr_data,
   input  vbe_pkg::queue_status_type  q_status,
   output logic                       push,
   output vbe_pkg::job_type           job
);

   logic       strip_ff, strip_in;
   logic       raw_tabs_ff, raw_tabs_in;
   logic [7:0] fold_ff, fold_in;
   logic [7:0] column_ff, column_in;
   logic       prev_space_ff, prev_space_in;

   logic       accept;
   logic       keep;
   logic       fold;
   logic [7:0] col_base;
   logic [7:0] c;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [2:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {6'b0, b};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

   assign c          = req_tdata;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign push       = accept && keep;

   assign fold     = !strip_ff && (c != vbe_pkg::CHAR_NEWLINE) && (column_ff >= fold_ff);
   assign col_base = fold ? vbe_pkg::FOLD_INDENT : column_ff;

   // classification
   always_comb begin
      keep      = 1'b1;
      job.fold  = fold;
      job.kind  = vbe_pkg::KIND_PLAIN;
      job.data  = c;
      column_in = column_ff;
      if (strip_ff) begin
         keep = ((c >= vbe_pkg::CHAR_SPACE) && (c <= vbe_pkg::CHAR_TILDE)) ||
                (c == vbe_pkg::CHAR_TAB) || (c == vbe_pkg::CHAR_NEWLINE);
      end else if (c == vbe_pkg::CHAR_NEWLINE) begin
         job.kind  = prev_space_ff ? vbe_pkg::KIND_NL_MARK : vbe_pkg::KIND_PLAIN;
         column_in = 8'd0;
      end else if (raw_tabs_ff && (c == vbe_pkg::CHAR_TAB)) begin
         column_in = sat_add(col_base | vbe_pkg::TAB_MASK, 3'd1);
      end else if ((c == vbe_pkg::CHAR_BACKSPACE) || (c == vbe_pkg::CHAR_BACKSLASH) ||
                   (c == vbe_pkg::CHAR_TAB)) begin
         job.kind  = vbe_pkg::KIND_PAIR;
         job.data  = (c == vbe_pkg::CHAR_BACKSPACE) ? vbe_pkg::CHAR_LOWER_B :
                     (c == vbe_pkg::CHAR_TAB) ? vbe_pkg::CHAR_LOWER_T : vbe_pkg::CHAR_BACKSLASH;
         column_in = sat_add(col_base, 3'd2);
      end else if (c[7] || (c < vbe_pkg::CHAR_SPACE) || (c == vbe_pkg::CHAR_DEL)) begin
         job.kind  = vbe_pkg::KIND_OCTAL;
         column_in = sat_add(col_base, 3'd4);
      end else begin
         column_in = sat_add(col_base, 3'd1);
      end
   end

   always_comb begin
      prev_space_in = prev_space_ff;
      if (accept && !strip_ff) begin
         prev_space_in = (c == vbe_pkg::CHAR_SPACE);
      end
   end

   always_comb begin
      strip_in    = strip_ff;
      raw_tabs_in = raw_tabs_ff;
      fold_in     = fold_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vbe_pkg::CSR_STRIP_MODE:  strip_in    = csr_data[0];
            vbe_pkg::CSR_RAW_TABS:    raw_tabs_in = csr_data[0];
            vbe_pkg::CSR_FOLD_COLUMN: fold_in     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff      <= 1'b0;
         raw_tabs_ff   <= 1'b0;
         fold_ff       <= vbe_pkg::FOLD_RESET;
         column_ff     <= 8'd0;
         prev_space_ff <= 1'b0;
      end else begin
         strip_ff      <= strip_in;
         raw_tabs_ff   <= raw_tabs_in;
         fold_ff       <= fold_in;
         prev_space_ff <= prev_space_in;
         if (accept) begin
            column_ff <= column_in;
         end
      end
   end

endmodule

// ===== hw/rtl/vbe_queue.sv =====
// short job queue between the front and back ends
`timescale 1ns / 1ps

module vbe_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vbe_pkg::job_type           push_job,
   input  logic                       pop,
   output vbe_pkg::job_type           head,
   output vbe_pkg::queue_status_type  q_status
);

   vbe_pkg::job_type entry_ff [vbe_pkg::QUEUE_DEPTH];

   logic [vbe_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vbe_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vbe_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == (vbe_pkg::QUEUE_AW + 1)'(vbe_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/vbe_back.sv =====
// back end: expands each job into output beats through an output register
`timescale 1ns / 1ps

module vbe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vbe_pkg::job_type           head,
   input  vbe_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast    // last_of_run
);

   logic [2:0] seq_ff, seq_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;

   logic       load;
   logic [2:0] body_len;
   logic [2:0] total_len;
   logic [2:0] body_idx;
   logic       last;
   logic [7:0] beat_byte;

   assign load = (!valid_ff || rsp_tready) && !q_status.empty;

   always_comb begin
      unique case (head.kind)
         vbe_pkg::KIND_PLAIN:   body_len = 3'd1;
         vbe_pkg::KIND_NL_MARK: body_len = 3'd3;
         vbe_pkg::KIND_PAIR:    body_len = 3'd2;
         vbe_pkg::KIND_OCTAL:   body_len = 3'd4;
         default:               body_len = 3'd1;
      endcase
   end

   assign total_len = head.fold ? body_len + 3'd3 : body_len;
   assign body_idx  = head.fold ? seq_ff - 3'd3 : seq_ff;
   assign last      = (seq_ff == total_len - 3'd1);
   assign pop       = load && last;

   // byte for the current beat
   always_comb begin
      beat_byte = head.data;
      if (head.fold && (seq_ff < 3'd3)) begin
         beat_byte = (seq_ff == 3'd0) ? vbe_pkg::CHAR_BACKSLASH :
                     (seq_ff == 3'd1) ? vbe_pkg::CHAR_NEWLINE : vbe_pkg::CHAR_TAB;
      end else begin
         unique case (head.kind)
            vbe_pkg::KIND_PLAIN: beat_byte = head.data;
            vbe_pkg::KIND_NL_MARK: begin
               beat_byte = (body_idx == 3'd0) ? vbe_pkg::CHAR_BACKSLASH :
                           (body_idx == 3'd1) ? vbe_pkg::CHAR_LOWER_N : vbe_pkg::CHAR_NEWLINE;
            end
            vbe_pkg::KIND_PAIR: begin
               beat_byte = (body_idx == 3'd0) ? vbe_pkg::CHAR_BACKSLASH : head.data;
            end
            vbe_pkg::KIND_OCTAL: begin
               unique case (body_idx[1:0])
                  2'd0:    beat_byte = vbe_pkg::CHAR_BACKSLASH;
                  2'd1:    beat_byte = vbe_pkg::CHAR_ZERO + {6'b0, head.data[7:6]};
                  2'd2:    beat_byte = vbe_pkg::CHAR_ZERO + {5'b0, head.data[5:3]};
                  default: beat_byte = vbe_pkg::CHAR_ZERO + {5'b0, head.data[2:0]};
               endcase
            end
            default: beat_byte = head.data;
         endcase
      end
   end

   always_comb begin
      seq_in   = seq_ff;
      valid_in = valid_ff;
      if (load) begin
         seq_in   = last ? 3'd0 : seq_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= beat_byte;
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/visible_byte_escaper_top.sv =====
// top level of the visible byte escaper
`timescale 1ns / 1ps

// Renders a byte stream in printable form. The front end takes one input beat per
// cycle while its four-entry job queue has room, updating the column and
// space-before-newline state at once; the back end turns each queued job into one to
// seven result beats, one per cycle while the receiver is ready, through a registered
// output stage, with tlast on the final beat of each input byte. Sustained rate is
// therefore set by the back end: an input byte takes one result beat for plain text,
// two for letter escapes, three for a newline after a space and four for octal
// escapes, plus three when a line is folded. Dropped bytes in strip mode give no
// beats. Configuration writes are taken every cycle and belong only to idle periods.

`include "visible_byte_escaper_top_assert.svh"

module visible_byte_escaper_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,    // last_of_run
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   vbe_pkg::queue_status_type q_status;
   vbe_pkg::job_type          push_job;
   vbe_pkg::job_type          head;
   logic                      push;
   logic                      pop;

   vbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .job        (push_job)
   );

   vbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   vbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `VBE_ASSERT_RESET_NEXT(a_reset_no_beat, reset, !rsp_tvalid)
   `VBE_ASSERT_IMP(a_no_push_when_full, push, !q_status.full)
   `VBE_ASSERT_IMP(a_no_pop_when_empty, pop, !q_status.empty)
   `VBE_ASSERT_NEXT(a_pop_shows_last, pop, rsp_tvalid && rsp_tlast)

endmodule

// ===== test/vbe_render_checker.sv =====
// checker for the visible byte escaper: predicts result beats and compares them
`timescale 1ns / 1ps

module vbe_render_checker
   import vbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int unsigned fail_count,
   output int unsigned pending
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } render_beat_type;

   render_beat_type expected_beats [$];
   render_beat_type want;

   logic       cfg_strip;
   logic       cfg_raw_tabs;
   logic [7:0] cfg_fold;
   logic [7:0] col_pos;
   logic       after_space;
   int unsigned errors;

   function automatic logic [7:0] col_sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = 9'(a) + 9'(b);
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   // works out the printable rendering of one input byte and queues its beats
   function automatic void render_byte(input logic [7:0] c);
      logic [7:0]      text [$];
      render_beat_type b;
      if (cfg_strip) begin
         if ((c >= CHAR_SPACE && c <= CHAR_TILDE) || c == CHAR_TAB || c == CHAR_NEWLINE)
            text.push_back(c);
      end else if (c == CHAR_NEWLINE) begin
         if (after_space) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(CHAR_LOWER_N);
         end
         text.push_back(c);
         col_pos = 8'd0;
      end else begin
         if (col_pos >= cfg_fold) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(CHAR_NEWLINE);
            text.push_back(CHAR_TAB);
            col_pos = FOLD_INDENT;
         end
         if (cfg_raw_tabs && c == CHAR_TAB) begin
            col_pos = col_pos | TAB_MASK;
            text.push_back(c);
         end else if (c == CHAR_BACKSPACE || c == CHAR_BACKSLASH || c == CHAR_TAB) begin
            text.push_back(CHAR_BACKSLASH);
            if (c == CHAR_BACKSPACE)
               text.push_back(CHAR_LOWER_B);
            else if (c == CHAR_TAB)
               text.push_back(CHAR_LOWER_T);
            else
               text.push_back(CHAR_BACKSLASH);
            col_pos = col_sat_add(col_pos, 8'd1);
         end else if (c[7] || c < CHAR_SPACE || c == CHAR_DEL) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(CHAR_ZERO + 8'(c[7:6]));
            text.push_back(CHAR_ZERO + 8'(c[5:3]));
            text.push_back(CHAR_ZERO + 8'(c[2:0]));
            col_pos = col_sat_add(col_pos, 8'd3);
         end else begin
            text.push_back(c);
         end
         col_pos = col_sat_add(col_pos, 8'd1);
      end
      if (!cfg_strip)
         after_space = (c == CHAR_SPACE);
      foreach (text[i]) begin
         b.out_byte    = text[i];
         b.last_of_run = (i == text.size() - 1);
         expected_beats.push_back(b);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_strip    = 1'b0;
         cfg_raw_tabs = 1'b0;
         cfg_fold     = FOLD_RESET;
         col_pos      = 8'd0;
         after_space  = 1'b0;
         errors       = 0;
         expected_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result beat out_byte %02h last_of_run %0b",
                           $realtime, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_beats.pop_front();
               if (want.out_byte !== rsp_tdata || want.last_of_run !== rsp_tlast) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: out_byte exp %02h got %02h, last_of_run exp %0b got %0b",
                              $realtime, want.out_byte, rsp_tdata, want.last_of_run,
                              rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            render_byte(req_tdata);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_STRIP_MODE:  cfg_strip    = csr_data[0];
               CSR_RAW_TABS:    cfg_raw_tabs = csr_data[0];
               CSR_FOLD_COLUMN: cfg_fold     = csr_data;
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending    <= expected_beats.size();
   end

endmodule

// ===== test/tb.sv =====
// testbench top for the visible byte escaper: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb;
   import vbe_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index  = 2'd0;
   logic [7:0] csr_data   = 8'd0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned cycle_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   logic [7:0] burst [$];

   visible_byte_escaper_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   vbe_render_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready  <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("visible_byte_escaper_top verification failed");
      $finish;
   end

   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic strip, input logic raw, input logic [7:0] fold);
      write_reg(CSR_STRIP_MODE, {7'd0, strip});
      write_reg(CSR_RAW_TABS, {7'd0, raw});
      write_reg(CSR_FOLD_COLUMN, fold);
      csr_valid <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_burst;
      foreach (burst[i]) send_byte(burst[i]);
   endtask

   // stops sending, waits until no result beats are expected, then drains further
   task automatic wait_drained;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] text_byte(input int nl_pct);
      int r;
      if ($urandom_range(99) < nl_pct)
         return CHAR_NEWLINE;
      r = $urandom_range(99);
      if (r < 40)
         return 8'($urandom_range(8'h21, 8'h7E));
      else if (r < 55)
         return CHAR_SPACE;
      else if (r < 63)
         return CHAR_TAB;
      else if (r < 68)
         return $urandom_range(1) ? CHAR_BACKSLASH : CHAR_BACKSPACE;
      else
         return 8'($urandom_range(255));
   endfunction

   initial begin
      logic       strip;
      logic       raw;
      logic [7:0] fold;
      int         nl_pct;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // octal extremes, letter escapes, space before newline, folding at the low end
      configure(1'b0, 1'b0, 8'd8);
      burst = '{8'h00, 8'hFF, CHAR_DEL, CHAR_TILDE, CHAR_SPACE, CHAR_NEWLINE,
                CHAR_BACKSPACE, CHAR_BACKSLASH, CHAR_TAB, 8'h41, 8'h80, 8'h1F,
                CHAR_NEWLINE};
      send_burst();
      wait_drained();

      // raw tabs with a zero threshold
      configure(1'b0, 1'b1, 8'd0);
      burst = '{CHAR_TAB, 8'h41, CHAR_TAB, CHAR_SPACE};
      send_burst();
      wait_drained();

      // strip mode drops and passes, leaving the space flag alone
      configure(1'b1, 1'b0, FOLD_RESET);
      burst = '{8'h00, CHAR_TAB, CHAR_NEWLINE, CHAR_DEL, 8'h41, 8'hFF, 8'h41};
      send_burst();
      wait_drained();

      configure(1'b0, 1'b0, FOLD_RESET);
      send_byte(CHAR_NEWLINE);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         case (p)
            0: begin strip = 1'b0; raw = 1'b0; fold = 8'd66;  nl_pct = 2; end
            1: begin strip = 1'b0; raw = 1'b1; fold = 8'd8;   nl_pct = 5; end
            2: begin strip = 1'b1; raw = 1'b0; fold = 8'd66;  nl_pct = 5; end
            3: begin strip = 1'b0; raw = 1'b0; fold = 8'd200; nl_pct = 1; end
            4: begin strip = 1'b0; raw = 1'b1; fold = 8'd255; nl_pct = 0; end
            5: begin strip = 1'b0; raw = 1'b0; fold = 8'd0;   nl_pct = 5; end
            6: begin strip = 1'b1; raw = 1'b1; fold = 8'd8;   nl_pct = 5; end
            default: begin
               strip = 1'b0; raw = 1'b0; fold = 8'($urandom_range(8, 200)); nl_pct = 3;
            end
         endcase
         configure(strip, raw, fold);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         repeat (54) send_byte(text_byte(nl_pct));
      end
      wait_drained();

      if (fail_count == 0)
         $display("visible_byte_escaper_top verification clean");
      else
         $display("visible_byte_escaper_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vbe_pkg.sv
hw/rtl/vbe_front.sv
hw/rtl/vbe_queue.sv
hw/rtl/vbe_back.sv
hw/rtl/visible_byte_escaper_top.sv
test/vbe_render_checker.sv
test/tb.sv
